/* hdl/rci_pkg.sv */
// rci_pkg: widths, constants and the per-stage data type of the rgb color interpolator
// used by rci_front, rci_div_cell and rgb_color_interpolator; no dependencies
package rci_pkg;

   localparam int CH_BITS      = 8;
   localparam int NUM_CH       = 3;
   localparam int COLOR_W      = CH_BITS * NUM_CH;
   localparam int TIME_W       = 32;
   localparam int NUM_W        = TIME_W + CH_BITS;
   localparam int STEP_COUNT   = CH_BITS;
   localparam int FRONT_STAGES = 3;
   localparam int PIPE_DEPTH   = FRONT_STAGES + STEP_COUNT;

   // partial remainder, remaining numerator bits / quotient bits, divisor
   typedef struct packed {
      logic [NUM_CH-1:0][TIME_W-1:0]  rem;
      logic [NUM_CH-1:0][CH_BITS-1:0] quo;
      logic [TIME_W-1:0]              div;
   } cell_data_type;

endpackage

/* hdl/rci_front.sv */
// rci_front: three-stage front end, special-case detect, channel products and numerator sum
// depends on rci_pkg
module rci_front
   import rci_pkg::*;
(
   input  logic                      clock,
   input  logic [FRONT_STAGES-1:0]   stage_en,
   input  logic [COLOR_W-1:0]        start_color,
   input  logic [COLOR_W-1:0]        end_color,
   input  logic [TIME_W-1:0]         elapsed_time,
   input  logic [TIME_W-1:0]         fade_duration,
   output cell_data_type             data_out
);

   // stage 1
   logic [COLOR_W-1:0] s1_start_ff, s1_end_ff;
   logic [TIME_W-1:0]  s1_diff_ff, s1_time_ff, s1_dur_ff;
   logic               s1_jump_ff;
   // stage 2
   logic [NUM_CH-1:0][NUM_W-1:0] s2_pa_ff, s2_pb_ff;
   logic [COLOR_W-1:0] s2_end_ff;
   logic [TIME_W-1:0]  s2_dur_ff;
   logic               s2_jump_ff;
   // stage 3
   cell_data_type      s3_data_ff, s3_data_in;

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         s1_start_ff <= start_color;
         s1_end_ff   <= end_color;
         s1_diff_ff  <= fade_duration - elapsed_time;
         s1_time_ff  <= elapsed_time;
         s1_dur_ff   <= fade_duration;
         s1_jump_ff  <= (fade_duration == '0) || (elapsed_time >= fade_duration);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         for (int c = 0; c < NUM_CH; c++) begin
            s2_pa_ff[c] <= {{TIME_W{1'b0}}, s1_start_ff[c*CH_BITS +: CH_BITS]}
                           * {{CH_BITS{1'b0}}, s1_diff_ff};
            s2_pb_ff[c] <= {{TIME_W{1'b0}}, s1_end_ff[c*CH_BITS +: CH_BITS]}
                           * {{CH_BITS{1'b0}}, s1_time_ff};
         end
         s2_end_ff  <= s1_end_ff;
         s2_dur_ff  <= s1_dur_ff;
         s2_jump_ff <= s1_jump_ff;
      end
   end

   always_comb begin
      logic [NUM_W-1:0] half;
      logic [NUM_W-1:0] acc;
      half = {{(CH_BITS+1){1'b0}}, s2_dur_ff[TIME_W-1:1]};
      s3_data_in = '0;
      for (int c = 0; c < NUM_CH; c++) begin
         // a jump divides the end channel by one, so the cells pass it through
         if (s2_jump_ff) begin
            acc = {{TIME_W{1'b0}}, s2_end_ff[c*CH_BITS +: CH_BITS]};
         end else begin
            acc = s2_pa_ff[c] + s2_pb_ff[c] + half;
         end
         s3_data_in.rem[c] = acc[NUM_W-1:CH_BITS];
         s3_data_in.quo[c] = acc[CH_BITS-1:0];
      end
      s3_data_in.div = s2_jump_ff ? TIME_W'(1) : s2_dur_ff;
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         s3_data_ff <= s3_data_in;
      end
   end

   assign data_out = s3_data_ff;

endmodule

/* hdl/rci_div_cell.sv */
// rci_div_cell: one restoring-division step for all three channels, one quotient bit each
// depends on rci_pkg
module rci_div_cell
   import rci_pkg::*;
(
   input  logic          clock,
   input  logic          enable,
   input  cell_data_type cell_i,
   output cell_data_type cell_o
);

   cell_data_type data_ff, data_in;

   always_comb begin
      logic [TIME_W:0] trial;
      logic [TIME_W:0] dvs;
      logic            qbit;
      dvs     = {1'b0, cell_i.div};
      data_in = cell_i;
      for (int c = 0; c < NUM_CH; c++) begin
         // bring down the next numerator bit
         trial = {cell_i.rem[c], cell_i.quo[c][CH_BITS-1]};
         qbit  = (trial >= dvs);
         if (qbit) begin
            data_in.rem[c] = TIME_W'(trial - dvs);
         end else begin
            data_in.rem[c] = trial[TIME_W-1:0];
         end
         data_in.quo[c] = {cell_i.quo[c][CH_BITS-2:0], qbit};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= data_in;
      end
   end

   assign cell_o = data_ff;

endmodule

/* hdl/rgb_color_interpolator.sv */
// rgb_color_interpolator: rounded linear fade between two packed rgb888 colors
// depends on rci_pkg, rci_front and rci_div_cell
//
//   channel   direction   ports
//   req       in          req_valid, req_ready, start/end color, elapsed time, duration
//   rsp       out         rsp_valid, rsp_ready, blended color
//
// one request per cycle while the output is not stalled; three front stages (compare, products, sum)
// and a chain of eight division cells, one quotient bit per cell
// the last cell is the output register; each stage advances when it is empty or its
// successor advances, so bubbles close up while the output stalls
// reset clears the stage valid bits only
module rgb_color_interpolator
   import rci_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [COLOR_W-1:0] req_start_color,
   input  logic [COLOR_W-1:0] req_end_color,
   input  logic [TIME_W-1:0]  req_elapsed_time,
   input  logic [TIME_W-1:0]  req_fade_duration,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [COLOR_W-1:0] rsp_blended_color
);

   logic [PIPE_DEPTH-1:0] valid_ff, valid_in;
   logic [PIPE_DEPTH-1:0] adv;
   cell_data_type         chain [STEP_COUNT+1];

   always_comb begin
      adv[PIPE_DEPTH-1] = !valid_ff[PIPE_DEPTH-1] || rsp_ready;
      for (int k = PIPE_DEPTH-2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
      valid_in = valid_ff;
      if (adv[0]) begin
         valid_in[0] = req_valid;
      end
      for (int k = 1; k < PIPE_DEPTH; k++) begin
         if (adv[k]) begin
            valid_in[k] = valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   rci_front u_front (
      .clock         (clock),
      .stage_en      (adv[FRONT_STAGES-1:0]),
      .start_color   (req_start_color),
      .end_color     (req_end_color),
      .elapsed_time  (req_elapsed_time),
      .fade_duration (req_fade_duration),
      .data_out      (chain[0])
   );

   for (genvar i = 0; i < STEP_COUNT; i++) begin : g_cell
      rci_div_cell u_cell (
         .clock  (clock),
         .enable (adv[FRONT_STAGES+i]),
         .cell_i (chain[i]),
         .cell_o (chain[i+1])
      );
   end

   assign req_ready = adv[0];
   assign rsp_valid = valid_ff[PIPE_DEPTH-1];

   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         rsp_blended_color[c*CH_BITS +: CH_BITS] = chain[STEP_COUNT].quo[c];
      end
   end

   // an accepted request lands in the first stage
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> valid_ff[0])
      else $error("accepted request missing from first stage");

   // full pipe with stalled output takes nothing
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (&valid_ff) && !rsp_ready |-> !req_ready)
      else $error("request taken while pipe is full and stalled");

   // a stalled middle stage keeps its request
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      valid_ff[FRONT_STAGES] && !adv[FRONT_STAGES] |=> valid_ff[FRONT_STAGES])
      else $error("stalled stage dropped its request");

   // occupancy grows by one on accept without delivery
   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !(rsp_valid && rsp_ready)
      |=> $countones(valid_ff) == $past($countones(valid_ff)) + 1)
      else $error("request lost or duplicated in pipe");

endmodule

/* bench/tb_rgb_color_interpolator.sv */
`timescale 1ns / 1ps
// tb_rgb_color_interpolator: self-checking bench for the rgb888 fade blender
// depends on rci_pkg and rgb_color_interpolator; queue-fed driver, monitor with a local blend model
module tb_rgb_color_interpolator;
   import rci_pkg::*;

   localparam int RANDOM_ITEMS = 1700;
   localparam int TAIL_ITEMS   = 150;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = PIPE_DEPTH + 8;

   typedef struct packed {
      logic [COLOR_W-1:0] start_color;
      logic [COLOR_W-1:0] end_color;
      logic [TIME_W-1:0]  elapsed;
      logic [TIME_W-1:0]  duration;
   } fade_req_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [COLOR_W-1:0] req_start_color = '0;
   logic [COLOR_W-1:0] req_end_color = '0;
   logic [TIME_W-1:0]  req_elapsed_time = '0;
   logic [TIME_W-1:0]  req_fade_duration = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [COLOR_W-1:0] rsp_blended_color;

   fade_req_type       pending_fades[$];
   logic [COLOR_W-1:0] blended_q[$];

   int mismatches   = 0;
   int n_requests   = 0;
   int n_jumps      = 0;
   int n_held_end   = 0;
   int n_checked    = 0;
   int send_gap     = 0;
   int send_pct     = 10;
   int recv_gap     = 0;
   int recv_pct     = 10;
   int stall_cycles = 0;

   rgb_color_interpolator u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_start_color   (req_start_color),
      .req_end_color     (req_end_color),
      .req_elapsed_time  (req_elapsed_time),
      .req_fade_duration (req_fade_duration),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_blended_color (rsp_blended_color)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // rounded per-channel blend; end color once elapsed reaches duration or duration is zero
   function automatic logic [COLOR_W-1:0] blend_rgb(input fade_req_type f);
      logic [COLOR_W-1:0] mix;
      logic [63:0]        acc;
      logic [63:0]        quot;
      logic [TIME_W-1:0]  left;
      mix = f.end_color;
      if (f.duration != '0 && f.elapsed < f.duration) begin
         left = f.duration - f.elapsed;
         for (int ch = 0; ch < NUM_CH; ch++) begin
            acc = 64'(f.start_color[ch*CH_BITS +: CH_BITS]) * 64'(left)
                + 64'(f.end_color[ch*CH_BITS +: CH_BITS]) * 64'(f.elapsed)
                + 64'(f.duration >> 1);
            quot = acc / 64'(f.duration);
            mix[ch*CH_BITS +: CH_BITS] = quot[CH_BITS-1:0];
         end
      end
      return mix;
   endfunction

   function automatic logic [COLOR_W-1:0] pick_color();
      logic [COLOR_W-1:0] c;
      c = COLOR_W'($urandom);
      // push single channels to their rails now and then
      for (int ch = 0; ch < NUM_CH; ch++) begin
         case ($urandom_range(5))
            0: c[ch*CH_BITS +: CH_BITS] = '0;
            1: c[ch*CH_BITS +: CH_BITS] = '1;
            default: ;
         endcase
      end
      return c;
   endfunction

   function automatic int pick_idle_pct();
      case ($urandom_range(4))
         0, 1: return 0;
         2: return 5;
         3: return 20;
         default: return 45;
      endcase
   endfunction

   task automatic push_fade(input logic [COLOR_W-1:0] s, input logic [COLOR_W-1:0] e,
                            input logic [TIME_W-1:0] t, input logic [TIME_W-1:0] d);
      fade_req_type f;
      f.start_color = s;
      f.end_color   = e;
      f.elapsed     = t;
      f.duration    = d;
      pending_fades.push_back(f);
   endtask

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("[%0t] MISMATCH: %s", $realtime, what);
   endtask

   // driver: load the next request when the port is free, or hold off for a burst
   always @(posedge clock) begin
      fade_req_type f;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            f.start_color = req_start_color;
            f.end_color   = req_end_color;
            f.elapsed     = req_elapsed_time;
            f.duration    = req_fade_duration;
            blended_q.push_back(blend_rgb(f));
            n_requests++;
            if (f.duration == '0)
               n_jumps++;
            else if (f.elapsed >= f.duration)
               n_held_end++;
            if (n_requests % 128 == 0)
               send_pct = pick_idle_pct();
         end
         if (!req_valid || req_ready) begin
            if (send_gap != 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_fades.size() == 0) begin
               req_valid <= 1'b0;
            end else if (pending_fades.size() > TAIL_ITEMS && $urandom_range(99) < send_pct) begin
               send_gap = $urandom_range(14, 0);
               req_valid <= 1'b0;
            end else begin
               f = pending_fades.pop_front();
               req_start_color   <= f.start_color;
               req_end_color     <= f.end_color;
               req_elapsed_time  <= f.elapsed;
               req_fade_duration <= f.duration;
               req_valid         <= 1'b1;
            end
         end
      end
   end

   // monitor: check each accepted result, then decide the next ready level
   always @(posedge clock) begin
      logic [COLOR_W-1:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (blended_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result %06h", rsp_blended_color));
         end else begin
            want = blended_q.pop_front();
            n_checked++;
            if (rsp_blended_color !== want)
               report_mismatch($sformatf("blended_color got %06h want %06h",
                                         rsp_blended_color, want));
         end
         if (n_checked % 100 == 0)
            recv_pct = pick_idle_pct();
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (recv_gap != 0) begin
         recv_gap--;
         rsp_ready <= 1'b0;
      end else if (pending_fades.size() > TAIL_ITEMS && $urandom_range(99) < recv_pct) begin
         recv_gap = $urandom_range(14, 0);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("timeout: no handshake for %0d cycles, %0d results outstanding",
                  STALL_LIMIT, blended_q.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      logic [TIME_W-1:0] d;
      logic [TIME_W-1:0] t;
      logic [COLOR_W-1:0] s;

      // directed: jumps, end reached or passed, start point, rounding ties, extremes
      push_fade(24'h000000, 24'hFFFFFF, 32'h0000_0000, 32'h0000_0000);
      push_fade(24'hFFFFFF, 24'h000000, 32'h0000_3039, 32'h0000_0000);
      push_fade(24'hFFFFFF, 24'hFFFFFF, 32'hFFFF_FFFF, 32'h0000_0000);
      push_fade(24'h000000, 24'h000000, 32'h0000_0000, 32'h0000_0000);
      push_fade(24'h123456, 24'hABCDEF, 32'h0000_0064, 32'h0000_0064);
      push_fade(24'hFF00FF, 24'h00FF00, 32'hFFFF_FFFF, 32'h0000_0001);
      push_fade(24'hFF00FF, 24'h00FF00, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_fade(24'hA5C3E7, 24'h000000, 32'h0000_0000, 32'hFFFF_FFFF);
      push_fade(24'hFFFFFF, 24'h000000, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
      push_fade(24'h000000, 24'hFFFFFF, 32'h0000_0001, 32'hFFFF_FFFF);
      push_fade(24'h000000, 24'hFFFFFF, 32'h0000_0000, 32'h0000_0001);
      push_fade(24'h00FF01, 24'hFF0000, 32'h0000_0001, 32'h0000_0002);
      push_fade(24'h010101, 24'h020202, 32'h0000_0001, 32'h0000_0002);
      push_fade(24'h000000, 24'hFFFFFF, 32'h0000_0001, 32'h0000_0003);
      push_fade(24'h000000, 24'hFFFFFF, 32'h0000_0002, 32'h0000_0003);
      push_fade(24'hFFFFFF, 24'hFFFFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      push_fade(24'h800000, 24'h7F0080, 32'h8000_0000, 32'hFFFF_FFFF);
      push_fade(24'h000000, 24'hFFFFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFE);
      push_fade(24'hFFFFFF, 24'h000000, 32'h8000_0000, 32'h8000_0001);
      push_fade(24'hFF8001, 24'h01807F, 32'h0000_0003, 32'h0000_0007);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         case ($urandom_range(9))
            0: begin
               d = '0;
               t = $urandom;
            end
            1: begin
               // elapsed at or beyond the end of the fade
               d = $urandom >> $urandom_range(31);
               t = ($urandom_range(1) == 0) ? d : d + 32'($urandom_range(1000) + 1);
               if (t < d)
                  t = d;
            end
            2: begin
               d = $urandom_range(16, 1);
               t = $urandom_range(d - 1, 0);
            end
            3: begin
               d = $urandom >> $urandom_range(31);
               if (d == '0)
                  d = 32'd1;
               t = $urandom % d;
            end
            4: begin
               // just short of the end on long fades
               d = $urandom | 32'h8000_0000;
               t = d - 32'($urandom_range(4, 1));
            end
            5: begin
               d = $urandom;
               t = $urandom;
            end
            default: begin
               d = $urandom;
               if (d == '0)
                  d = 32'hFFFF_FFFF;
               t = $urandom % d;
            end
         endcase
         s = pick_color();
         push_fade(s, ($urandom_range(15) == 0) ? s : pick_color(), t, d);
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (pending_fades.size() != 0 || req_valid || blended_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (blended_q.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", blended_q.size()));
      $display("covered %0d fade requests (%0d zero-duration jumps, %0d at or past the end)",
               n_requests, n_jumps, n_held_end);
      $display("checked %0d blended colors, %0d mismatches", n_checked, mismatches);
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

/* filelist.f */
hdl/rci_pkg.sv
hdl/rci_front.sv
hdl/rci_div_cell.sv
hdl/rgb_color_interpolator.sv
bench/tb_rgb_color_interpolator.sv
